@@ src/bsff_pkg.sv @@
// Shared types, constants and sizing for the bitmap store find-first block.
package bsff_pkg;

    localparam int BIT_COUNT   = 8192;
    // Word width is a power of two and a multiple of eight.
    localparam int WORD_BITS   = 64;
    localparam int STORE_WORDS = (BIT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int WB_LOG      = $clog2(WORD_BITS);
    localparam int NB          = WORD_BITS / 8;
    localparam int BYTE_W      = (NB > 1) ? $clog2(NB) : 1;

    localparam int CMD_W       = 2;
    localparam int IDX_W       = 13;
    localparam int UB_W        = 11;
    localparam int PROD_W      = UB_W + 3;
    localparam int SPAN_W      = $clog2(BIT_COUNT) + 1;
    localparam int LIM_W       = (PROD_W > SPAN_W) ? PROD_W : SPAN_W;
    localparam int FULL_W      = ADDR_W + WB_LOG;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [UB_W-1:0] UB_RESET       = UB_W'(1024);
    localparam logic [0:0]      REG_USED_BYTES = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_FILL  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic issue;
        logic flush;
        logic load_out;
    } t_dp_ctl;

    typedef struct packed {
        logic skip;
        logic last;
        logic hit;
        logic busy;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/bsff_ctrl.sv @@
// Controller state machine that sequences each transaction through the datapath.
module bsff_ctrl
    import bsff_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_ctl.accept   = 1'b0;
        o_ctl.issue    = 1'b0;
        o_ctl.flush    = 1'b0;
        o_ctl.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = i_stat.skip ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.issue = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_FINISH;
                end else if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.hit || !i_stat.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.flush = 1'b1;
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_skip_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.accept && i_stat.skip |=> r_state == S_FINISH)
        else $error("skipped transaction did not go straight to finish");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !i_stat.busy)
        else $error("pipeline still busy while idle");

    a_load_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |=> r_state == S_IDLE && !i_stat.busy)
        else $error("result loaded but controller not idle");

endmodule

@@ src/bsff_dpath.sv @@
// Datapath: word memory, scan pipeline, bit update, first-match encoder and result register.
module bsff_dpath
    import bsff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [IDX_W-1:0]  i_bit_index,
    input  logic              i_bit_value,
    input  logic [UB_W-1:0]   i_used_bytes,
    input  t_dp_ctl           i_ctl,
    output t_dp_stat          o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_bit_read,
    output logic [IDX_W-1:0]  o_first_index,
    output logic              o_found,
    output logic              o_status
);

    logic [WORD_BITS-1:0] mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_wvld;

    // Command registers captured at accept.
    t_cmd              r_cmd;
    logic              r_val;
    logic [WB_LOG-1:0] r_off;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_last;

    // Stage 1: registered read data.
    logic                 r_s1_v;
    logic [ADDR_W-1:0]    r_s1_addr;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_s1_dv;

    // Stage 2: per-byte match summary.
    logic              r_s2_v;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [NB-1:0]     r_s2_any;
    logic [2:0]        r_s2_pos [NB];

    // Result being built and output register.
    logic             r_res_bit, r_res_found, r_res_status;
    logic [IDX_W-1:0] r_res_first;
    logic             r_out_valid;

    logic [LIM_W-1:0]     w_prod, w_lim, w_lim_m1, w_idx_ext;
    logic                 w_single, w_skip;
    logic [WORD_BITS-1:0] w_d, w_mask, w_match, w_wdata;
    logic                 w_part, w_wr_en;
    logic [NB-1:0]        w_any;
    logic [2:0]           w_pos [NB];
    logic [BYTE_W-1:0]    w_sel;
    logic [FULL_W-1:0]    w_full;
    logic                 w_hit;
    logic                 w_out_free;

    // Span in bits, saturated at the store size.
    assign w_prod    = LIM_W'(i_used_bytes) << 3;
    assign w_lim     = (w_prod > LIM_W'(BIT_COUNT)) ? LIM_W'(BIT_COUNT) : w_prod;
    assign w_lim_m1  = w_lim - LIM_W'(1);
    assign w_idx_ext = LIM_W'(i_bit_index);
    assign w_single  = (t_cmd'(i_cmd) == CMD_WRITE) || (t_cmd'(i_cmd) == CMD_READ);
    assign w_skip    = w_single ? (w_idx_ext >= w_lim) : (w_lim == '0);

    // Stage 1 logic.
    assign w_d    = r_s1_dv ? r_rdata : '0;
    assign w_part = (r_s1_addr == r_last) && (w_lim[WB_LOG-1:0] != '0);
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_mask[j] = !w_part || (WB_LOG'(j) < w_lim[WB_LOG-1:0]);
        end
    end
    assign w_match = (r_val ? w_d : ~w_d) & w_mask;
    assign w_wr_en = r_s1_v && ((r_cmd == CMD_WRITE) || (r_cmd == CMD_FILL));

    always_comb begin
        w_wdata = w_d;
        case (r_cmd)
            CMD_WRITE: w_wdata[r_off] = r_val;
            CMD_FILL:  w_wdata = (w_d & ~w_mask) | (r_val ? w_mask : '0);
            default:   w_wdata = w_d;
        endcase
    end

    always_comb begin
        for (int b = 0; b < NB; b++) begin
            w_any[b] = |w_match[b*8 +: 8];
            w_pos[b] = 3'd0;
            for (int k = 7; k >= 0; k--) begin
                if (w_match[b*8 + k]) begin
                    w_pos[b] = 3'(k);
                end
            end
        end
    end

    // Stage 2 logic: lowest byte with a match.
    always_comb begin
        w_sel = '0;
        for (int b = NB - 1; b >= 0; b--) begin
            if (r_s2_any[b]) begin
                w_sel = BYTE_W'(b);
            end
        end
    end
    assign w_full = (FULL_W'(r_s2_addr) << WB_LOG) | (FULL_W'(w_sel) << 3)
                  | FULL_W'(r_s2_pos[w_sel]);
    assign w_hit  = r_s2_v && (|r_s2_any);

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_stat.skip     = w_skip;
    assign o_stat.last     = (r_addr == r_last);
    assign o_stat.hit      = w_hit;
    assign o_stat.busy     = r_s1_v || r_s2_v;
    assign o_stat.out_free = w_out_free;

    // Memory: one read and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_rdata <= mem[r_addr];
        end
        if (w_wr_en) begin
            mem[r_s1_addr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (w_wr_en) begin
            r_wvld[r_s1_addr] <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_val  <= i_bit_value;
            r_off  <= i_bit_index[WB_LOG-1:0];
            r_addr <= w_single ? ADDR_W'(w_idx_ext >> WB_LOG) : '0;
            r_last <= w_single ? ADDR_W'(w_idx_ext >> WB_LOG) : ADDR_W'(w_lim_m1 >> WB_LOG);
        end else if (i_ctl.issue) begin
            r_addr <= r_addr + 1'b1;
        end
        if (i_ctl.issue) begin
            r_s1_addr <= r_addr;
            r_s1_dv   <= r_wvld[r_addr];
        end
        r_s2_addr <= r_s1_addr;
        r_s2_any  <= w_any;
        r_s2_pos  <= w_pos;
    end

    // Pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_ctl.issue && !i_ctl.flush;
            r_s2_v <= r_s1_v && (r_cmd == CMD_FIND) && !i_ctl.flush;
        end
    end

    // Result accumulation.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_res_bit    <= 1'b0;
            r_res_first  <= '0;
            r_res_found  <= 1'b0;
            r_res_status <= w_single && w_skip;
        end else begin
            if (r_s1_v && (r_cmd == CMD_READ)) begin
                r_res_bit <= w_d[r_off];
            end
            if (w_hit && !r_res_found && !i_ctl.flush) begin
                r_res_found <= 1'b1;
                r_res_first <= IDX_W'(w_full);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_bit_read    <= r_res_bit;
            o_first_index <= r_res_first;
            o_found       <= r_res_found;
            o_status      <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_write_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> r_s1_addr <= r_last)
        else $error("memory write beyond the last word of the transaction");

    a_hit_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> r_s2_addr <= r_last && r_cmd == CMD_FIND)
        else $error("match reported outside a find or beyond the span");

endmodule

@@ src/bitmap_store_find_first_core.sv @@
// Top level of the bitmap store with bit write, bit read, find-first and fill commands.
// Find and fill walk one stored word per cycle over a span of at most 128 words, a find
// ending early on its first match. One transaction is handled at a time; the next is
// accepted the cycle after a result is registered. An out-of-range command skips the scan.
// Reset (synchronous, active low) clears per-word valid bits so the store reads as zero
// at once, with no clearing pass, and sets used_bytes to 1024.
module bitmap_store_find_first_core
    import bsff_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [IDX_W-1:0]   i_bit_index,
    input  logic               i_bit_value,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_bit_read,
    output logic [IDX_W-1:0]   o_first_index,
    output logic               o_found,
    output logic               o_status,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [UB_W-1:0] r_used_bytes;
    t_dp_ctl         w_ctl;
    t_dp_stat        w_stat;
    logic            w_reg_hit;

    // The register file holds only used_bytes, at byte offset zero. The word index
    // is taken from the address bits above the byte lane.
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[PADDR_W-1:2] == REG_USED_BYTES);
    assign prdata    = w_reg_hit ? PDATA_W'(r_used_bytes) : '0;

    // A write lands on the access phase; pready is tied high so it completes at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_bytes <= UB_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_used_bytes <= pwdata[UB_W-1:0];
        end
    end

    // The controller decides when to accept, scan, flush and publish a result; the
    // datapath owns the memory, the scan pipeline and the output register.
    bsff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    bsff_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_bit_index   (i_bit_index),
        .i_bit_value   (i_bit_value),
        .i_used_bytes  (r_used_bytes),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_bit_read    (o_bit_read),
        .o_first_index (o_first_index),
        .o_found       (o_found),
        .o_status      (o_status)
    );

endmodule

@@ test/bsff_tb_pkg.sv @@
// Expected-result tracking for the bitmap store find-first testbench.
package bsff_tb_pkg;

    import bsff_pkg::*;

    typedef struct packed {
        logic             bit_read;
        logic [IDX_W-1:0] first_index;
        logic             found;
        logic             status;
    } t_answer;

    class bit_store_model;

        logic [BIT_COUNT-1:0] bitmap;
        logic [UB_W-1:0]      used_bytes;
        t_answer              answers[$];
        int                   mismatch_count;
        int                   checked;

        function new();
            bitmap         = '0;
            used_bytes     = UB_RESET;
            mismatch_count = 0;
            checked        = 0;
        endfunction

        function void set_used_bytes(logic [UB_W-1:0] value);
            used_bytes = value;
        endfunction

        // Bits in use, saturated at the size of the store.
        function int span_bits();
            int bits;
            bits = int'(used_bytes) * 8;
            return (bits > BIT_COUNT) ? BIT_COUNT : bits;
        endfunction

        function int outstanding();
            return answers.size();
        endfunction

        // Applies one accepted command to the shadow store and queues its answer.
        function void take_command(t_cmd cmd, logic [IDX_W-1:0] idx, logic value);
            t_answer ans;
            int      limit;
            ans   = '0;
            limit = span_bits();
            case (cmd)
                CMD_WRITE: begin
                    if (int'(idx) < limit) bitmap[idx] = value;
                    else ans.status = 1'b1;
                end
                CMD_READ: begin
                    if (int'(idx) < limit) ans.bit_read = bitmap[idx];
                    else ans.status = 1'b1;
                end
                CMD_FIND: begin
                    for (int i = 0; i < limit; i++) begin
                        if (bitmap[i] == value) begin
                            ans.found       = 1'b1;
                            ans.first_index = IDX_W'(i);
                            break;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < limit; i++) bitmap[i] = value;
                end
            endcase
            answers.push_back(ans);
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatch_count++;
        endtask

        task compare_field(string field, int got, int want);
            if (got != want)
                flag_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
                                        checked, field, got, want));
        endtask

        task match_answer(t_answer got);
            t_answer want;
            if (answers.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                        checked));
                checked++;
                return;
            end
            want = answers.pop_front();
            compare_field("bit_read", got.bit_read, want.bit_read);
            compare_field("first_index", got.first_index, want.first_index);
            compare_field("found", got.found, want.found);
            compare_field("status", got.status, want.status);
            checked++;
        endtask

    endclass

endpackage

@@ test/tb_top.sv @@
// Self-checking testbench for the bitmap store find-first core.
module tb_top;

    import bsff_pkg::*;
    import bsff_tb_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_cmd;
    logic [IDX_W-1:0]   i_bit_index;
    logic               i_bit_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_bit_read;
    logic [IDX_W-1:0]   o_first_index;
    logic               o_found;
    logic               o_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow of the store and the queue of answers still owed by the block.
    bit_store_model store_model;

    // Set for the final stretch of the run, where neither side idles.
    bit steady_flow = 1'b0;
    // Raised by the command side to make the result side hold off for a long time.
    bit hold_off_request = 1'b0;
    int items_sent = 0;

    bitmap_store_find_first_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_bit_index   (i_bit_index),
        .i_bit_value   (i_bit_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bit_read    (o_bit_read),
        .o_first_index (o_first_index),
        .o_found       (o_found),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The slowest correct run (every command a full-span find or fill, every result
    // stalled, every command delayed) stays well below this.
    initial begin : watchdog
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // Offers one command and holds it until the block takes it. A random idle burst may
    // come first, so that gaps fall on every phase of the block's work. The caller is
    // always just past a rising edge, and valid is only ever assigned once per edge.
    task automatic send_command(t_cmd cmd, logic [IDX_W-1:0] idx, logic value);
        if (!steady_flow && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_bit_index <= idx;
        i_bit_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        store_model.take_command(cmd, idx, value);
        items_sent++;
    endtask

    // Stops offering commands and waits until every owed result has come back. Every
    // command yields exactly one result, so the block is idle once the queue is empty.
    // At least one edge always passes, so the caller again stands just past an edge.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (store_model.outstanding() != 0);
    endtask

    // Register write, setup phase then access phase; the data is taken at the edge of the access
    // phase at which pready is high.
    task automatic write_used_bytes(logic [UB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_USED_BYTES) << 2;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        store_model.set_used_bytes(value);
    endtask

    // Most indexes fall inside the span in use, some just past it, some anywhere.
    function automatic logic [IDX_W-1:0] pick_index(int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (span > 0 && roll < 75) return IDX_W'($urandom_range(0, span - 1));
        if (span < BIT_COUNT && roll < 82) return IDX_W'(span);
        if (span < BIT_COUNT && roll < 92) return IDX_W'($urandom_range(span, BIT_COUNT - 1));
        return IDX_W'($urandom_range(0, BIT_COUNT - 1));
    endfunction

    // Random commands at the current setting. Fills are common enough that the store
    // swings between mostly clear and mostly set, so that finds for either value land
    // at varied positions, including none at all.
    task automatic run_random_phase(int count);
        int span;
        int roll;
        span = store_model.span_bits();
        for (int n = 0; n < count; n++) begin
            // Once in the run the result side stalls long enough to back up the block.
            if (items_sent == 300) hold_off_request = 1'b1;
            // Once in the run the command side waits until everything has come back.
            if (items_sent == 700) drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 35)
                send_command(CMD_WRITE, pick_index(span), 1'($urandom_range(0, 1)));
            else if (roll < 63)
                send_command(CMD_READ, pick_index(span), 1'($urandom_range(0, 1)));
            else if (roll < 92)
                send_command(CMD_FIND, pick_index(span), 1'($urandom_range(0, 1)));
            else
                send_command(CMD_FILL, pick_index(span), 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: checks every accepted result against the oldest owed answer, then
    // decides ready for the next edge. Ready idles in short random bursts, once for a
    // long stretch on request, and not at all in the final phase.
    initial begin : result_sink
        int      hold_cycles;
        t_answer got;
        hold_cycles = 0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.bit_read    = o_bit_read;
                got.first_index = o_first_index;
                got.found       = o_found;
                got.status      = o_status;
                store_model.match_answer(got);
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_cycles      = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
                hold_cycles = $urandom_range(0, 11);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int phase_bytes[12];
        store_model = new();

        // Every input known from the start, with reset held low.
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_WRITE;
        i_bit_index <= '0;
        i_bit_value <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset setting, where the whole store is in use. The store
        // starts clear, so a search for a set bit finds nothing while one for a clear bit
        // stops at the bottom. Then the top and bottom bits, a fill with ones, a lone
        // clear bit in the middle, and a fill back to zeros.
        send_command(CMD_READ,  IDX_W'(0),             1'b0);
        send_command(CMD_FIND,  IDX_W'(0),             1'b1);
        send_command(CMD_FIND,  IDX_W'(0),             1'b0);
        send_command(CMD_WRITE, IDX_W'(BIT_COUNT - 1), 1'b1);
        send_command(CMD_READ,  IDX_W'(BIT_COUNT - 1), 1'b0);
        send_command(CMD_FIND,  IDX_W'(0),             1'b1);
        send_command(CMD_WRITE, IDX_W'(0),             1'b1);
        send_command(CMD_FIND,  IDX_W'(BIT_COUNT - 1), 1'b1);
        send_command(CMD_FILL,  IDX_W'(0),             1'b1);
        send_command(CMD_FIND,  IDX_W'(0),             1'b0);
        send_command(CMD_WRITE, IDX_W'(4096),          1'b0);
        send_command(CMD_FIND,  IDX_W'(0),             1'b0);
        send_command(CMD_READ,  IDX_W'(4095),          1'b1);
        send_command(CMD_FILL,  IDX_W'(0),             1'b0);
        send_command(CMD_FIND,  IDX_W'(0),             1'b1);
        drain_results();

        // One byte in use: the last bit in range, the first bit past it for a write and
        // a read, and a fill that must leave the rest of the store alone.
        write_used_bytes(UB_W'(1));
        send_command(CMD_WRITE, IDX_W'(7),             1'b1);
        send_command(CMD_WRITE, IDX_W'(8),             1'b1);
        send_command(CMD_READ,  IDX_W'(8),             1'b0);
        send_command(CMD_FILL,  IDX_W'(8191),          1'b1);
        send_command(CMD_FIND,  IDX_W'(3),             1'b0);
        drain_results();

        // No bytes in use: writes and reads are out of range, a find fails and a fill
        // changes nothing.
        write_used_bytes(UB_W'(0));
        send_command(CMD_WRITE, IDX_W'(0),             1'b1);
        send_command(CMD_READ,  IDX_W'(0),             1'b0);
        send_command(CMD_FIND,  IDX_W'(0),             1'b0);
        send_command(CMD_FILL,  IDX_W'(0),             1'b1);
        drain_results();

        // Random part over a range of settings, mostly small spans so that finds and
        // fills stay short, with the largest values and saturation among them. The last
        // phase runs at the reset value with no idling on either side.
        phase_bytes = '{1, 0, 2047, 3, 1025, 16, 1, 1023, 128, 1, 64, 1024};
        phase_bytes[6] = $urandom_range(1, 32);
        phase_bytes[9] = $urandom_range(1, 1024);
        foreach (phase_bytes[p]) begin
            write_used_bytes(UB_W'(phase_bytes[p]));
            if (p == $size(phase_bytes) - 1) steady_flow = 1'b1;
            run_random_phase(110);
            drain_results();
        end

        // Let any stray result from the longest walk show up before the verdict.
        repeat (150) @(posedge i_clk);
        if (store_model.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
